>>> rtl/rgae_pkg.sv
// shared types, constants and blend helpers for the glyph alpha-blend expander
// no dependencies
package rgae_pkg;

    localparam logic [31:0] BLEND_MASK  = 32'h07E0_F81F;
    localparam int          CFG_IDX_W   = 8;
    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 8'd1;
    localparam logic        CMD_GLYPH   = 1'b0;
    localparam logic        CMD_IMAGE   = 1'b1;

    // command bundle from the controller to the datapath
    typedef struct packed {
        logic load_item;   // capture the accepted byte
        logic load_prod;   // register the weighted colour difference
        logic load_pix;    // register the finished pixel
        logic sel_lo;      // use the low nibble as alpha
    } t_dp_cmd;

    // spread rgb565 into the packed-field form
    function automatic logic [31:0] spread(input logic [15:0] c);
        spread = {c, c} & BLEND_MASK;
    endfunction

    // fold the packed fields back into rgb565
    function automatic logic [15:0] fold(input logic [31:0] r);
        logic [31:0] m;
        m    = r & BLEND_MASK;
        fold = m[31:16] | m[15:0];
    endfunction

endpackage

>>> rtl/rgae_dp.sv
// datapath: colour registers, item capture, two-step blend and output pixel register
// depends on rgae_pkg
module rgae_dp import rgae_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic [7:0]           i_data_byte,
    input  t_dp_cmd              i_cmd,
    output logic [15:0]          o_pixel
);

    logic [15:0] r_fg;
    logic [15:0] r_bg;
    logic [7:0]  r_byte;
    logic [31:0] r_prod;
    logic [15:0] r_pix;

    logic [3:0]  level;
    logic [31:0] weight;
    logic [31:0] diff;
    logic [31:0] n_prod;
    logic [31:0] sum;

    always_comb begin
        level  = i_cmd.sel_lo ? r_byte[3:0] : r_byte[7:4];
        weight = {27'd0, level, 1'b0};
        diff   = spread(r_fg) - spread(r_bg);
        n_prod = diff * weight;
        sum    = {5'd0, r_prod[31:5]} + spread(r_bg);
    end

    // both colours come up black
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= 16'h0000;
            r_bg <= 16'h0000;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_FG_COLOR) begin
                r_fg <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == REG_BG_COLOR) begin
                r_bg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_byte <= i_data_byte;
        end
        if (i_cmd.load_prod) begin
            r_prod <= n_prod;
        end
        if (i_cmd.load_pix) begin
            r_pix <= fold(sum);
        end
    end

    assign o_pixel = r_pix;

endmodule

>>> rtl/rgae_ctrl.sv
// controller: item acceptance, blend sequencing and pixel count
// depends on rgae_pkg
module rgae_ctrl import rgae_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_command,
    input  logic [3:0] i_count,
    input  logic       i_out_stall,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output logic       o_last,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_image, n_image;
    logic [3:0] r_left,  n_left;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_xfer = (r_state == S_OUT) && !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_image = r_image;
        n_left  = r_left;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_image = i_command;
                    n_left  = (i_command == CMD_IMAGE) ? 4'd2 : i_count;
                    if (i_command == CMD_IMAGE || i_count != 4'd0) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: n_state = S_ADD;
            S_ADD: n_state = S_OUT;
            S_OUT: begin
                if (out_xfer) begin
                    n_left = r_left - 4'd1;
                    if (r_left == 4'd1) begin
                        n_state = S_IDLE;
                    end else if (r_image) begin
                        n_state = S_MUL;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_image <= 1'b0;
            r_left  <= 4'd0;
        end else begin
            r_state <= n_state;
            r_image <= n_image;
            r_left  <= n_left;
        end
    end

    always_comb begin
        o_cmd.load_item = in_xfer;
        o_cmd.load_prod = (r_state == S_MUL);
        o_cmd.load_pix  = (r_state == S_ADD);
        // image bytes show the high nibble first
        o_cmd.sel_lo    = !r_image || (r_left == 4'd1);
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_last      = (r_left == 4'd1);

endmodule

>>> rtl/rle_glyph_alpha_blend_expander_core.sv
// top level of the run-length glyph / packed image alpha-blend expander
// depends on rgae_pkg, rgae_ctrl and rgae_dp
//
// Each input byte becomes zero or more rgb565 pixels, each a blend of the
// foreground and background colour registers at alpha weight 2a/32. A glyph
// byte (command 0) carries a count in its high nibble and the alpha in its
// low nibble and gives count pixels of one colour; a count of zero gives no
// pixel. An image byte (command 1) gives two pixels, high nibble first. The
// last pixel of every byte has o_last set. One byte is handled at a time:
// after the accept each distinct alpha goes through the weighted colour-difference
// multiply, then the add and repack into the output register, and each pixel
// waits in the output register until the sink takes it. Colour registers are
// written over the cfg port, which is always ready; write them only while
// no byte is in flight.
module rle_glyph_alpha_blend_expander_core import rgae_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input byte channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_command,
    input  logic [7:0]           i_data_byte,
    // pixel channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [15:0]          o_pixel,
    output logic                 o_last,
    // register write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    t_dp_cmd dp_cmd;

    // registers take a transfer on any cycle
    assign o_cfg_ready = 1'b1;

    rgae_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .i_count     (i_data_byte[7:4]),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_last      (o_last),
        .o_cmd       (dp_cmd)
    );

    rgae_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_data_byte (i_data_byte),
        .i_cmd       (dp_cmd),
        .o_pixel     (o_pixel)
    );

endmodule

>>> rtl/rgae_checker.sv
// port-level checks for the expander top level, attached by bind
// depends on rle_glyph_alpha_blend_expander_core
module rgae_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_command,
    input logic [7:0]  i_data_byte,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_pixel,
    input logic        o_last
);

    // a stalled pixel holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel) && $stable(o_last))
        else $error("pixel transfer dropped or changed under stall");

    // a byte that yields pixels keeps the input side busy
    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command || i_data_byte[7:4] != 4'd0)
        |=> o_in_stall && !o_out_valid)
        else $error("input not held off after a producing byte");

    // no new byte while a pixel is offered
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while a pixel is pending");

    // reset leaves nothing to deliver
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("pixel offered after reset");

endmodule

bind rle_glyph_alpha_blend_expander_core rgae_checker u_rgae_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_command   (i_command),
    .i_data_byte (i_data_byte),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_pixel     (o_pixel),
    .o_last      (o_last)
);

>>> sim/rle_glyph_alpha_blend_expander_core_test.sv
// self-checking testbench for the rle glyph / packed image alpha-blend expander
// depends on rgae_pkg and rle_glyph_alpha_blend_expander_core
// directed table then random bytes, each pixel compared with a table value or a local blend model
`timescale 1ns / 1ps

module rle_glyph_alpha_blend_expander_core_test;
    import rgae_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    // a zero-count byte may still be in flight when the last pixel has gone
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int QUIET_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 40;
    localparam int PHASE_ITEMS   = 88;

    // indexes with no register behind them, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'd255;

    // one pixel we are waiting for
    typedef struct packed {
        logic [15:0] pixel;
        logic        last;
    } t_pixel_exp;

    // one row of the directed table: either a register write or a byte
    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          val;
        logic                 cmd;
        logic [7:0]           data;
        logic                 typed;      // exp_pixel holds the answer for every pixel
        logic [15:0]          exp_pixel;
    } t_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic                 i_command   = CMD_GLYPH;
    logic [7:0]           i_data_byte = 8'h00;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [15:0]          o_pixel;
    logic                 o_last;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_FG_COLOR;
    logic [15:0]          i_cfg_data  = 16'h0000;

    // local copy of the colour registers, updated on each accepted write
    logic [15:0]  model_fg = 16'h0000;
    logic [15:0]  model_bg = 16'h0000;

    t_pixel_exp   pending_px[$];
    t_row         directed_rows[$];

    int           in_idle_pct   = 0;
    int           out_stall_pct = 0;
    int           error_count   = 0;
    int           pixels_seen   = 0;
    int           quiet_cycles  = 0;

    rle_glyph_alpha_blend_expander_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pixel     (o_pixel),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // blend of the current colours at alpha level, 32-bit wrapping arithmetic
    function automatic logic [15:0] blend_colour(input logic [3:0] level);
        logic [31:0] fg_wide;
        logic [31:0] bg_wide;
        logic [31:0] weight;
        logic [31:0] acc;
        fg_wide = {model_fg, model_fg} & BLEND_MASK;
        bg_wide = {model_bg, model_bg} & BLEND_MASK;
        weight  = {27'd0, level, 1'b0};
        // the difference may go negative, the wrap is intended
        acc     = (fg_wide - bg_wide) * weight;
        acc     = (acc >> 5) + bg_wide;
        acc     = acc & BLEND_MASK;
        return acc[31:16] | acc[15:0];
    endfunction

    // queue the pixels that one accepted byte gives
    task automatic expand_byte(input logic cmd, input logic [7:0] data,
                               input logic typed, input logic [15:0] exp_pixel);
        logic [15:0] px_hi;
        logic [15:0] px_lo;
        px_hi = typed ? exp_pixel : blend_colour(data[7:4]);
        px_lo = typed ? exp_pixel : blend_colour(data[3:0]);
        if (cmd == CMD_IMAGE) begin
            // high nibble first, the low nibble closes the byte
            pending_px.push_back('{pixel: px_hi, last: 1'b0});
            pending_px.push_back('{pixel: px_lo, last: 1'b1});
        end else begin
            // run of count pixels at the low-nibble alpha, count zero gives none
            for (int k = 0; k < int'(data[7:4]); k++) begin
                pending_px.push_back('{pixel: px_lo, last: (k + 1 == int'(data[7:4]))});
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("mismatch at pixel %0d: %s, got %h want %h", pixels_seen, what, got, want);
        end
    endtask

    // present one byte, with random idle cycles ahead of it, and wait for the transfer
    task automatic send_byte(input logic cmd, input logic [7:0] data,
                             input logic typed, input logic [15:0] exp_pixel);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        // valid is left high after the transfer so back-to-back bytes need no toggle
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_data_byte <= data;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        expand_byte(cmd, data, typed, exp_pixel);
    endtask

    // stop sending and let every outstanding pixel drain out of the block
    task automatic settle_pixels();
        i_in_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write, only ever issued with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        settle_pixels();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        if (idx == REG_FG_COLOR) begin
            model_fg = val;
        end else if (idx == REG_BG_COLOR) begin
            model_bg = val;
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        directed_rows.push_back('{is_cfg: 1'b1, idx: idx, val: val, cmd: CMD_GLYPH,
                                  data: 8'h00, typed: 1'b0, exp_pixel: 16'h0000});
    endtask

    task automatic add_item(input logic cmd, input logic [7:0] data,
                            input logic typed, input logic [15:0] exp_pixel);
        directed_rows.push_back('{is_cfg: 1'b0, idx: REG_FG_COLOR, val: 16'h0000, cmd: cmd,
                                  data: data, typed: typed, exp_pixel: exp_pixel});
    endtask

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // pixel checker, samples the values that held just before the edge
    always @(posedge i_clk) begin : pixel_check
        t_pixel_exp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_px.size() == 0) begin
                report_mismatch("pixel with none expected", o_pixel, 16'h0000);
            end else begin
                want = pending_px.pop_front();
                if (o_pixel !== want.pixel) report_mismatch("pixel value", o_pixel, want.pixel);
                if (o_last !== want.last) begin
                    report_mismatch("last flag", {15'd0, o_last}, {15'd0, want.last});
                end
            end
            pixels_seen++;
        end
    end

    // watchdog: any transfer on any channel counts as progress
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("rle_glyph_alpha_blend_expander_core_test: done, errors");
            $finish;
        end
    end

    initial begin
        t_row       row;
        logic       cmd;
        logic [7:0] data;

        // straight after reset both colours are zero, so everything blends to black
        add_item(CMD_GLYPH, 8'hF5, 1'b1, 16'h0000);
        add_item(CMD_IMAGE, 8'hF0, 1'b1, 16'h0000);
        add_item(CMD_GLYPH, 8'h0A, 1'b0, 16'h0000);   // zero count, no pixel
        // white on black: alpha zero gives the background, full alpha is predicted
        add_cfg(REG_FG_COLOR, 16'hFFFF);
        add_cfg(REG_BG_COLOR, 16'h0000);
        add_item(CMD_GLYPH, 8'h10, 1'b1, 16'h0000);
        add_item(CMD_GLYPH, 8'hFF, 1'b0, 16'h0000);   // longest run, top alpha
        add_item(CMD_IMAGE, 8'hF0, 1'b0, 16'h0000);
        add_item(CMD_IMAGE, 8'h0F, 1'b0, 16'h0000);
        add_item(CMD_GLYPH, 8'h00, 1'b0, 16'h0000);
        add_item(CMD_GLYPH, 8'h1F, 1'b0, 16'h0000);
        // black on white: the colour difference wraps negative
        add_cfg(REG_FG_COLOR, 16'h0000);
        add_cfg(REG_BG_COLOR, 16'hFFFF);
        add_item(CMD_GLYPH, 8'h30, 1'b1, 16'hFFFF);
        add_item(CMD_GLYPH, 8'h2F, 1'b0, 16'h0000);
        add_item(CMD_IMAGE, 8'h00, 1'b1, 16'hFFFF);
        add_item(CMD_IMAGE, 8'hFF, 1'b0, 16'h0000);
        add_item(CMD_IMAGE, 8'h5A, 1'b0, 16'h0000);
        // writes to unused indexes must leave both colours alone
        add_cfg(REG_UNUSED_LO, 16'h1234);
        add_cfg(REG_UNUSED_HI, 16'hFFFF);
        add_item(CMD_GLYPH, 8'h10, 1'b1, 16'hFFFF);
        add_item(CMD_GLYPH, 8'h1F, 1'b0, 16'h0000);
        // equal colours blend to themselves at any alpha
        add_cfg(REG_FG_COLOR, 16'hA5A5);
        add_cfg(REG_BG_COLOR, 16'hA5A5);
        add_item(CMD_GLYPH, 8'h47, 1'b1, 16'hA5A5);
        add_item(CMD_IMAGE, 8'h3C, 1'b1, 16'hA5A5);
        // pure red over pure green, fields pulling in opposite directions
        add_cfg(REG_FG_COLOR, 16'hF800);
        add_cfg(REG_BG_COLOR, 16'h07E0);
        add_item(CMD_GLYPH, 8'h28, 1'b0, 16'h0000);
        add_item(CMD_IMAGE, 8'h81, 1'b0, 16'h0000);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part runs with no idling on either side
        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.is_cfg) begin
                write_reg(row.idx, row.val);
            end else begin
                send_byte(row.cmd, row.data, row.typed, row.exp_pixel);
            end
        end

        // random part, one phase per idling pattern
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 0;
                end
                1: begin
                    in_idle_pct   = 55;
                    out_stall_pct = 0;
                end
                2: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 55;
                end
                default: begin
                    in_idle_pct   = 36;
                    out_stall_pct = 36;
                end
            endcase
            // extreme colour pairs on even phases, random ones on odd
            if (ph == 0) begin
                write_reg(REG_FG_COLOR, 16'hFFFF);
                write_reg(REG_BG_COLOR, 16'h0000);
            end else if (ph == 2) begin
                write_reg(REG_FG_COLOR, 16'h0000);
                write_reg(REG_BG_COLOR, 16'hFFFF);
            end else begin
                write_reg(REG_FG_COLOR, 16'($urandom));
                write_reg(REG_BG_COLOR, 16'($urandom));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // fresh colours half way through each phase
                if (n == PHASE_ITEMS / 2) begin
                    write_reg(REG_FG_COLOR, 16'($urandom));
                    write_reg(REG_BG_COLOR, 16'($urandom));
                    if ($urandom_range(1) == 0) begin
                        write_reg(8'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)),
                                  16'($urandom));
                    end
                end
                cmd  = 1'($urandom_range(1));
                data = 8'($urandom_range(255));
                // extra weight on empty and single-pixel runs
                if ($urandom_range(7) == 0) data[7:4] = 4'($urandom_range(1));
                send_byte(cmd, data, 1'b0, 16'h0000);
            end
        end

        settle_pixels();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("rle_glyph_alpha_blend_expander_core_test: done, clean");
        end else begin
            $display("rle_glyph_alpha_blend_expander_core_test: done, errors");
        end
        $finish;
    end

endmodule
